// ----- design/gedcom_line_tokenizer_core_macros.svh -----
// ----------------------------------------------------------------------------
// GEDCOM line tokenizer assertion macros
// Concurrent assertion helpers clocked on clk and disabled during reset.
// They compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GEDCOM_LINE_TOKENIZER_CORE_MACROS_SVH
`define GEDCOM_LINE_TOKENIZER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Invariant that must hold at every clock edge outside reset.
`define GLT_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("gedcom tokenizer invariant violated");

// Consequence that must hold in the cycle after the antecedent.
`define GLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gedcom tokenizer sequence violated");

`else

`define GLT_ASSERT(lbl, cond)
`define GLT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- design/glt_pkg.sv -----
// ----------------------------------------------------------------------------
// GEDCOM line tokenizer package
// Shared constants, character codes, phase encoding and the structs that
// travel between the tokenizer top level and its scan logic.
// ----------------------------------------------------------------------------
package glt_pkg;

  // In-line offsets and lengths saturate at this count.
  localparam int LINE_MAX      = 255;
  localparam int LINE_BITS     = $clog2(LINE_MAX + 1);
  // Width of the absolute byte position counter, which wraps.
  localparam int POSITION_BITS = 32;
  localparam int START_BITS    = 32;
  localparam int FIELD_BITS    = 8;
  localparam int LEVEL_BITS    = 4;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_LEVEL,
    PH_PRE1,
    PH_PRE2,
    PH_XREF,
    PH_POSTX,
    PH_TAG,
    PH_VALUE
  } phase_t;

  typedef logic [LINE_BITS-1:0] span_t;

  typedef struct packed {
    phase_t                   phase;
    logic [POSITION_BITS-1:0] pos;
    logic [POSITION_BITS-1:0] line_start;
    span_t                    offset;
    logic [LEVEL_BITS-1:0]    cur_level;
    logic [LEVEL_BITS-1:0]    line_level;
    logic                     line_valid;
    span_t                    xref_off;
    span_t                    xref_len;
    span_t                    tag_off;
    span_t                    tag_len;
    span_t                    val_off;
    span_t                    val_len;
    logic                     last_cr;
  } glt_state_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       first_byte;
    logic       stream_end;
  } glt_byte_t;

  typedef struct packed {
    logic [START_BITS-1:0] line_start;
    logic                  line_ok;
    logic                  close_before;
    logic                  hierarchy_skip;
    logic [LEVEL_BITS-1:0] tag_level;
    logic [FIELD_BITS-1:0] xref_offset;
    logic [FIELD_BITS-1:0] xref_length;
    logic [FIELD_BITS-1:0] tag_offset;
    logic [FIELD_BITS-1:0] tag_length;
    logic [FIELD_BITS-1:0] value_offset;
    logic [FIELD_BITS-1:0] value_length;
    logic                  final_line;
  } glt_result_t;

endpackage

// ----- design/glt_channels.sv -----
// ----------------------------------------------------------------------------
// GEDCOM line tokenizer channels
// Valid/ready interfaces for the text byte input and the line result output.
// ----------------------------------------------------------------------------
interface glt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       first_byte;
  logic       stream_end;

  modport source (output valid, output text_byte, output first_byte,
                  output stream_end, input ready);
  modport sink   (input valid, input text_byte, input first_byte,
                  input stream_end, output ready);
endinterface

interface glt_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [glt_pkg::START_BITS-1:0]        line_start;
  logic                                  line_ok;
  logic                                  close_before;
  logic                                  hierarchy_skip;
  logic [glt_pkg::LEVEL_BITS-1:0]        tag_level;
  logic [glt_pkg::FIELD_BITS-1:0]        xref_offset;
  logic [glt_pkg::FIELD_BITS-1:0]        xref_length;
  logic [glt_pkg::FIELD_BITS-1:0]        tag_offset;
  logic [glt_pkg::FIELD_BITS-1:0]        tag_length;
  logic [glt_pkg::FIELD_BITS-1:0]        value_offset;
  logic [glt_pkg::FIELD_BITS-1:0]        value_length;
  logic                                  final_line;

  modport source (output valid, output line_start, output line_ok,
                  output close_before, output hierarchy_skip, output tag_level,
                  output xref_offset, output xref_length, output tag_offset,
                  output tag_length, output value_offset, output value_length,
                  output final_line, input ready);
  modport sink   (input valid, input line_start, input line_ok,
                  input close_before, input hierarchy_skip, input tag_level,
                  input xref_offset, input xref_length, input tag_offset,
                  input tag_length, input value_offset, input value_length,
                  input final_line, output ready);
endinterface

// ----- design/gedcom_line_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// GEDCOM line tokenizer core
// Splits a GEDCOM byte stream into lines and reports level, xref, tag and
// value positions for each line.
// ----------------------------------------------------------------------------
// Usage:
// Text bytes arrive on in_chan, one item per byte, with first_byte marking
// the start of a document and stream_end its last byte. Bytes before the
// first '0' of a document are skipped. Each newline, and each stream_end
// byte, yields one line result item on out_chan; all other bytes yield none.
// An accepted item sits in the input register until the scan logic updates
// the tokenizer state and loads the result register, which drives out_chan.
// The design takes one byte per cycle, sustained while the receiver does
// not stall; that figure is set by the single scan step between the input
// and result registers, which carries the whole per-byte state update.
// When the receiver stalls, the result register holds its item and the byte
// in the input register waits, whether or not it would yield a result;
// in_chan.ready stays low while that byte cannot move, so nothing is lost.
// Reset (rst_n low, synchronous) empties both registers, returns the scan to
// waiting for the first '0' and clears the byte position and current level.
// ----------------------------------------------------------------------------
`include "gedcom_line_tokenizer_core_macros.svh"

module gedcom_line_tokenizer_core (
  input  logic      clk,
  input  logic      rst_n,
  glt_in_if.sink    in_chan,
  glt_out_if.source out_chan
);

  // Input register: one byte waiting for the scan step.
  logic                 in_v_r;
  logic                 in_v_nxt;
  glt_pkg::glt_byte_t   in_r;

  // Tokenizer state, updated once per scanned byte.
  glt_pkg::glt_state_t  state_r;
  glt_pkg::glt_state_t  state_nxt;

  // Result register feeding out_chan.
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  glt_pkg::glt_result_t out_r;

  glt_pkg::glt_result_t scan_res;
  logic                 scan_emit;
  logic                 fire;
  logic                 in_take;

  // State summaries used by the checks at the end of the module.
  logic                 st_wait;
  logic                 st_idle_line;
  logic                 st_fresh;

  // The byte in the input register is scanned whenever the result register
  // is free or is being emptied in this cycle.
  assign fire          = in_v_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_v_r || fire;
  assign in_take       = in_chan.valid && in_chan.ready;
  assign in_v_nxt      = in_take || (in_v_r && !fire);
  assign out_valid_nxt = (fire && scan_emit) || (out_valid_r && !out_chan.ready);

  glt_scan u_scan (
    .st_i   (state_r),
    .byte_i (in_r),
    .st_o   (state_nxt),
    .emit_o (scan_emit),
    .res_o  (scan_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      // The all-zero state is the wait phase with no open line.
      state_r     <= '0;
    end else begin
      in_v_r      <= in_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r.text_byte  <= in_chan.text_byte;
      in_r.first_byte <= in_chan.first_byte;
      in_r.stream_end <= in_chan.stream_end;
    end
    if (fire && scan_emit) begin
      out_r <= scan_res;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.line_start     = out_r.line_start;
  assign out_chan.line_ok        = out_r.line_ok;
  assign out_chan.close_before   = out_r.close_before;
  assign out_chan.hierarchy_skip = out_r.hierarchy_skip;
  assign out_chan.tag_level      = out_r.tag_level;
  assign out_chan.xref_offset    = out_r.xref_offset;
  assign out_chan.xref_length    = out_r.xref_length;
  assign out_chan.tag_offset     = out_r.tag_offset;
  assign out_chan.tag_length     = out_r.tag_length;
  assign out_chan.value_offset   = out_r.value_offset;
  assign out_chan.value_length   = out_r.value_length;
  assign out_chan.final_line     = out_r.final_line;

  assign st_wait      = (state_r.phase == glt_pkg::PH_WAIT);
  assign st_idle_line = (state_r.offset == '0) && !state_r.line_valid &&
                        (state_r.line_start == '0);
  assign st_fresh     = st_wait || (state_r.phase == glt_pkg::PH_LEVEL);

  // While waiting for a document's first '0', no line is open.
  `GLT_ASSERT(a_wait_clear, !st_wait || st_idle_line)

  // Only a line that has scanned no byte yet has a zero in-line count.
  `GLT_ASSERT(a_offset_live, st_fresh == (state_r.offset == '0))

  // The last byte of a document always produces a result item.
  `GLT_ASSERT_NEXT(a_end_result, fire && in_r.stream_end, out_valid_r && out_r.final_line)

endmodule

// ----- design/glt_scan.sv -----
// ----------------------------------------------------------------------------
// GEDCOM line tokenizer scan step
// Combinational next-state and line-result logic for one text byte.
// ----------------------------------------------------------------------------
module glt_scan (
  input  glt_pkg::glt_state_t  st_i,
  input  glt_pkg::glt_byte_t   byte_i,
  output glt_pkg::glt_state_t  st_o,
  output logic                 emit_o,
  output glt_pkg::glt_result_t res_o
);

  function automatic glt_pkg::span_t sat_inc(glt_pkg::span_t v);
    return (v < glt_pkg::LINE_BITS'(glt_pkg::LINE_MAX)) ?
           v + glt_pkg::LINE_BITS'(1) : glt_pkg::LINE_BITS'(glt_pkg::LINE_MAX);
  endfunction

  function automatic glt_pkg::span_t span(glt_pkg::span_t from, glt_pkg::span_t upto);
    return (upto > from) ? upto - from : '0;
  endfunction

  function automatic glt_pkg::glt_state_t clear_line(glt_pkg::glt_state_t st);
    glt_pkg::glt_state_t r;
    r            = st;
    r.offset     = '0;
    r.line_level = '0;
    r.line_valid = 1'b0;
    r.xref_off   = '0;
    r.xref_len   = '0;
    r.tag_off    = '0;
    r.tag_len    = '0;
    r.val_off    = '0;
    r.val_len    = '0;
    r.last_cr    = 1'b0;
    return r;
  endfunction

  glt_pkg::glt_state_t a;
  glt_pkg::glt_state_t s;
  glt_pkg::glt_state_t n;
  logic [7:0]          c;
  logic [7:0]          dig;
  logic                blank;
  logic                space;
  logic                ok;
  logic                vl_trim;
  glt_pkg::span_t      off;
  glt_pkg::span_t      fin_end;
  glt_pkg::span_t      xo;
  glt_pkg::span_t      xl;
  glt_pkg::span_t      to_off;
  glt_pkg::span_t      tl;
  glt_pkg::span_t      vo;
  glt_pkg::span_t      vl;

  assign c     = byte_i.text_byte;
  assign dig   = c - glt_pkg::CH_ZERO;
  assign blank = (c == glt_pkg::CH_SP) || (c == glt_pkg::CH_TAB);
  assign space = blank || (c == glt_pkg::CH_LF) || (c == glt_pkg::CH_VT) ||
                 (c == glt_pkg::CH_FF) || (c == glt_pkg::CH_CR);

  // Byte scan: document restart, line start from the wait phase, field phases.
  always_comb begin
    a = st_i;
    if (byte_i.first_byte) begin
      a            = clear_line(st_i);
      a.phase      = glt_pkg::PH_WAIT;
      a.pos        = '0;
      a.line_start = '0;
    end
    off = a.offset;
    s   = a;
    if (a.phase == glt_pkg::PH_WAIT) begin
      if (c == glt_pkg::CH_ZERO) begin
        s            = clear_line(a);
        s.phase      = glt_pkg::PH_PRE1;
        s.line_start = a.pos;
        s.line_valid = 1'b1;
        s.offset     = glt_pkg::LINE_BITS'(1);
      end
    end else if (c != glt_pkg::CH_LF) begin
      case (a.phase)
        glt_pkg::PH_LEVEL: begin
          if (c >= glt_pkg::CH_ZERO && c <= glt_pkg::CH_NINE) begin
            s.line_level = dig[glt_pkg::LEVEL_BITS-1:0];
            s.line_valid = 1'b1;
            s.phase      = glt_pkg::PH_PRE1;
          end else begin
            s.line_valid = 1'b0;
            s.phase      = glt_pkg::PH_VALUE;
          end
        end
        glt_pkg::PH_PRE1, glt_pkg::PH_PRE2: begin
          if (c == glt_pkg::CH_AT) begin
            s.xref_off = sat_inc(off);
            s.phase    = glt_pkg::PH_XREF;
          end else if (blank && a.phase == glt_pkg::PH_PRE1) begin
            s.phase = glt_pkg::PH_PRE2;
          end else if (blank) begin
            s.tag_off = sat_inc(off);
            s.phase   = glt_pkg::PH_TAG;
          end else begin
            // The byte opens the tag and is scanned again as a tag byte.
            s.tag_off = off;
            if (space) begin
              s.tag_len = '0;
              s.val_off = off;
              s.phase   = glt_pkg::PH_VALUE;
            end else begin
              s.phase = glt_pkg::PH_TAG;
            end
          end
        end
        glt_pkg::PH_XREF: begin
          if (c == glt_pkg::CH_AT) begin
            s.xref_len = span(a.xref_off, off);
            s.phase    = glt_pkg::PH_POSTX;
          end
        end
        glt_pkg::PH_POSTX: begin
          if (blank) begin
            s.tag_off = sat_inc(off);
            s.phase   = glt_pkg::PH_TAG;
          end else begin
            s.tag_off = off;
            if (space) begin
              s.tag_len = '0;
              s.val_off = off;
              s.phase   = glt_pkg::PH_VALUE;
            end else begin
              s.phase = glt_pkg::PH_TAG;
            end
          end
        end
        glt_pkg::PH_TAG: begin
          if (space) begin
            s.tag_len = span(a.tag_off, off);
            s.val_off = blank ? sat_inc(off) : off;
            s.phase   = glt_pkg::PH_VALUE;
          end
        end
        default: begin
        end
      endcase
      s.last_cr = (c == glt_pkg::CH_CR);
      s.offset  = sat_inc(off);
    end
  end

  // Line close: fill in the fields the scan never reached.
  always_comb begin
    fin_end = s.offset;
    ok      = s.line_valid && (s.phase != glt_pkg::PH_LEVEL);
    xo      = s.xref_off;
    xl      = s.xref_len;
    to_off  = s.tag_off;
    tl      = s.tag_len;
    vo      = s.val_off;
    vl      = s.val_len;
    vl_trim = 1'b0;
    case (s.phase)
      glt_pkg::PH_PRE1, glt_pkg::PH_PRE2, glt_pkg::PH_POSTX: begin
        to_off = fin_end;
        tl     = '0;
        vo     = fin_end;
        vl     = '0;
      end
      glt_pkg::PH_XREF: begin
        xl     = span(s.xref_off, fin_end);
        to_off = fin_end;
        tl     = '0;
        vo     = fin_end;
        vl     = '0;
      end
      glt_pkg::PH_TAG: begin
        tl = span(s.tag_off, fin_end);
        vo = fin_end;
        vl = '0;
      end
      default: begin
        vl = span(s.val_off, fin_end);
        // A trailing carriage return is dropped unless the line was clipped.
        vl_trim = s.last_cr && (vl != '0) &&
                  (fin_end < glt_pkg::LINE_BITS'(glt_pkg::LINE_MAX));
        if (vl_trim) begin
          vl = vl - glt_pkg::LINE_BITS'(1);
        end
      end
    endcase
    if (xl == '0 && s.phase != glt_pkg::PH_XREF && s.phase != glt_pkg::PH_POSTX) begin
      xo = '0;
    end

    emit_o = ((a.phase != glt_pkg::PH_WAIT) && (c == glt_pkg::CH_LF)) || byte_i.stream_end;

    res_o            = '0;
    res_o.final_line = byte_i.stream_end;
    if (s.phase != glt_pkg::PH_WAIT) begin
      res_o.line_start = glt_pkg::START_BITS'(s.line_start);
    end
    if (ok) begin
      res_o.line_ok        = 1'b1;
      res_o.close_before   = (s.line_level <= s.cur_level);
      res_o.hierarchy_skip = ({1'b0, s.line_level} >
                              ({1'b0, s.cur_level} + (glt_pkg::LEVEL_BITS + 1)'(1)));
      res_o.tag_level      = s.line_level;
      res_o.xref_offset    = glt_pkg::FIELD_BITS'(xo);
      res_o.xref_length    = glt_pkg::FIELD_BITS'(xl);
      res_o.tag_offset     = glt_pkg::FIELD_BITS'(to_off);
      res_o.tag_length     = glt_pkg::FIELD_BITS'(tl);
      res_o.value_offset   = glt_pkg::FIELD_BITS'(vo);
      res_o.value_length   = glt_pkg::FIELD_BITS'(vl);
    end
  end

  // Next state after the byte and any line close.
  always_comb begin
    n     = s;
    n.pos = a.pos + glt_pkg::POSITION_BITS'(1);
    if (ok && emit_o) begin
      n.cur_level = s.line_level;
    end
    if (byte_i.stream_end) begin
      n            = clear_line(n);
      n.phase      = glt_pkg::PH_WAIT;
      n.pos        = '0;
      n.line_start = '0;
    end else if (emit_o) begin
      n            = clear_line(n);
      n.phase      = glt_pkg::PH_LEVEL;
      n.line_start = a.pos + glt_pkg::POSITION_BITS'(1);
    end
    st_o = n;
  end

endmodule

// ----- tb/tb_gedcom_line_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// GEDCOM line tokenizer core testbench
// Streams short directed text, then randomized GEDCOM documents with noise,
// through the tokenizer under random idling on both channels. A built-in
// line scanner predicts every line result, and each result item is checked
// field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_gedcom_line_tokenizer_core;
  import glt_pkg::*;

  // The run stops on its own long before this; reaching it means a hang.
  localparam int CYCLE_LIMIT   = 1000000;
  // Document bytes in the random part; noise bursts come on top.
  localparam int FEED_TARGET   = 1800;
  // A result passes only the input and result registers behind its byte, so a short settle is enough.
  localparam int SETTLE_CYCLES = 8;

  // One text byte waiting to be offered, with the idle cycles that precede
  // it and a flag that holds it back until every line result is in.
  typedef struct packed {
    glt_byte_t  beat;
    logic [7:0] gap;
    logic       drain;
  } feed_t;

  logic clk;
  logic rst_n;

  glt_in_if  in_chan ();
  glt_out_if out_chan ();

  gedcom_line_tokenizer_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  feed_t       feed_q[$];
  glt_result_t lines_due[$];
  logic [7:0]  doc_buf[$];

  int  mismatches = 0;
  int  cycles = 0;
  bit  in_calm = 1'b0;
  int  gap_left = 0;
  bit  gap_armed = 1'b0;
  int  stall_left = 0;
  int  calm_left = 0;

  // --------------------------------------------------------------------------
  // Line scanner state. It mirrors what the tokenizer tracks: the scan phase
  // within the current line, the absolute byte position in the document, the
  // start of the current line, the saturating column, the level of the line
  // and of the last valid line, and the six field spans.
  // --------------------------------------------------------------------------
  phase_t      scan_phase;
  logic [31:0] byte_pos;
  logic [31:0] line_begin;
  logic [7:0]  col;
  logic [3:0]  cur_level;
  logic [3:0]  line_lvl;
  logic        line_good;
  logic        prev_cr;
  logic [7:0]  xref_at, xref_len, tag_at, tag_len, val_at, val_len;

  // Column arithmetic stops at the line limit instead of wrapping.
  function automatic logic [7:0] clip_inc(logic [7:0] v);
    return (v < LINE_MAX) ? v + 8'd1 : 8'(LINE_MAX);
  endfunction

  function automatic logic [7:0] gap_len(logic [7:0] from_col, logic [7:0] to_col);
    return (to_col > from_col) ? to_col - from_col : 8'd0;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  function automatic bit is_ws(logic [7:0] c);
    return is_blank(c) || c == CH_LF || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

  function automatic void clear_line();
    col       = 8'd0;
    line_lvl  = 4'd0;
    line_good = 1'b0;
    prev_cr   = 1'b0;
    xref_at   = 8'd0;
    xref_len  = 8'd0;
    tag_at    = 8'd0;
    tag_len   = 8'd0;
    val_at    = 8'd0;
    val_len   = 8'd0;
  endfunction

  // A new document forgets everything except the level of the last valid line.
  function automatic void new_document();
    scan_phase = PH_WAIT;
    byte_pos   = 32'd0;
    line_begin = 32'd0;
    clear_line();
  endfunction

  // Advances the line scan by one byte that is neither skipped nor a newline.
  // A byte that ends the blanks ahead of the tag is scanned a second time as
  // the first byte of the tag, so a tag can be empty when that byte is white.
  function automatic void scan_char(logic [7:0] c);
    logic [7:0] off;
    bit         again;
    off   = col;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (scan_phase)
        PH_LEVEL: begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            line_lvl   = 4'(c - CH_ZERO);
            line_good  = 1'b1;
            scan_phase = PH_PRE1;
          end else begin
            line_good  = 1'b0;
            scan_phase = PH_VALUE;
          end
        end
        PH_PRE1, PH_PRE2: begin
          if (c == CH_AT) begin
            xref_at    = clip_inc(off);
            scan_phase = PH_XREF;
          end else if (is_blank(c) && scan_phase == PH_PRE1) begin
            scan_phase = PH_PRE2;
          end else if (is_blank(c)) begin
            tag_at     = clip_inc(off);
            scan_phase = PH_TAG;
          end else begin
            tag_at     = off;
            scan_phase = PH_TAG;
            again      = 1'b1;
          end
        end
        PH_XREF: begin
          if (c == CH_AT) begin
            xref_len   = gap_len(xref_at, off);
            scan_phase = PH_POSTX;
          end
        end
        PH_POSTX: begin
          tag_at     = is_blank(c) ? clip_inc(off) : off;
          again      = !is_blank(c);
          scan_phase = PH_TAG;
        end
        PH_TAG: begin
          if (is_ws(c)) begin
            tag_len    = gap_len(tag_at, off);
            val_at     = is_blank(c) ? clip_inc(off) : off;
            scan_phase = PH_VALUE;
          end
        end
        default: ;
      endcase
    end
    prev_cr = (c == CH_CR);
    col     = clip_inc(off);
  endfunction

  // Closes the current line into a result. Fields that the scan never reached
  // are placed at the line end; a trailing carriage return is dropped from
  // the value unless the line was clipped.
  function automatic void close_text_line(input bit last, output glt_result_t r);
    r            = '0;
    r.line_start = line_begin;
    r.final_line = last;
    if (line_good && scan_phase != PH_LEVEL) begin
      case (scan_phase)
        PH_PRE1, PH_PRE2, PH_POSTX, PH_XREF: begin
          if (scan_phase == PH_XREF) xref_len = gap_len(xref_at, col);
          tag_at  = col;
          tag_len = 8'd0;
          val_at  = col;
          val_len = 8'd0;
        end
        PH_TAG: begin
          tag_len = gap_len(tag_at, col);
          val_at  = col;
          val_len = 8'd0;
        end
        default: begin
          val_len = gap_len(val_at, col);
          if (prev_cr && val_len != 8'd0 && col < LINE_MAX) val_len = val_len - 8'd1;
        end
      endcase
      if (xref_len == 8'd0 && scan_phase != PH_XREF && scan_phase != PH_POSTX)
        xref_at = 8'd0;
      r.line_ok        = 1'b1;
      r.close_before   = line_lvl <= cur_level;
      r.hierarchy_skip = {1'b0, line_lvl} > {1'b0, cur_level} + 5'd1;
      r.tag_level      = line_lvl;
      r.xref_offset    = xref_at;
      r.xref_length    = xref_len;
      r.tag_offset     = tag_at;
      r.tag_length     = tag_len;
      r.value_offset   = val_at;
      r.value_length   = val_len;
      cur_level        = line_lvl;
    end
    scan_phase = PH_LEVEL;
    clear_line();
  endfunction

  // Takes one accepted text byte; returns 1 when it closes a line or ends the stream.
  function automatic bit tokenize_byte(input glt_byte_t b, output glt_result_t r);
    bit got;
    got = 1'b0;
    r   = '0;
    if (b.first_byte) new_document();
    if (scan_phase == PH_WAIT) begin
      // Everything ahead of the first zero of a document is skipped.
      if (b.text_byte == CH_ZERO) begin
        scan_phase = PH_LEVEL;
        line_begin = byte_pos;
        clear_line();
        scan_char(b.text_byte);
      end
    end else if (b.text_byte == CH_LF) begin
      close_text_line(b.stream_end, r);
      got        = 1'b1;
      line_begin = byte_pos + 32'd1;
    end else begin
      scan_char(b.text_byte);
    end
    byte_pos = byte_pos + 32'd1;
    if (b.stream_end) begin
      // The last byte always yields a result, even for a document with no zero.
      if (!got) begin
        if (scan_phase == PH_WAIT) begin
          r            = '0;
          r.final_line = 1'b1;
        end else begin
          close_text_line(1'b1, r);
        end
        got = 1'b1;
      end
      new_document();
    end
    return got;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Idle lengths: mostly none, often a few cycles, now and then a long pause.
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] tag_char();
    return ($urandom_range(0, 19) == 0) ? 8'h5F : 8'(8'h41 + $urandom_range(0, 25));
  endfunction

  // Value text is mostly printable, but any byte other than a newline occurs.
  function automatic logic [7:0] value_char();
    logic [7:0] c;
    if ($urandom_range(0, 99) < 75) return 8'($urandom_range(32, 126));
    do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
    return c;
  endfunction

  // Appends one byte to the document being built.
  task automatic put_text(logic [7:0] c);
    doc_buf = {doc_buf, c};
  endtask

  task automatic add_byte(logic [7:0] c, bit first, bit last, bit drain);
    feed_t f;
    f.beat.text_byte  = c;
    f.beat.first_byte = first;
    f.beat.stream_end = last;
    f.gap             = in_calm ? 8'd0 : 8'(idle_span());
    f.drain           = drain;
    feed_q = {feed_q, f};
  endtask

  task automatic add_blank();
    put_text(($urandom_range(0, 3) == 0) ? CH_TAB : CH_SP);
  endtask

  // Zero, one or two blanks; a second blank shifts where the next field starts.
  task automatic add_blanks();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 80) add_blank();
    else if (k < 88) begin
      add_blank();
      add_blank();
    end
  endtask

  // A well-formed line: level, optional xref (sometimes empty or unclosed),
  // tag (sometimes empty), optional separator and value, optional CR.
  task automatic add_valid_line(int unsigned lvl);
    int unsigned k;
    put_text(8'(CH_ZERO + lvl));
    add_blanks();
    if ($urandom_range(0, 99) < 35) begin
      put_text(CH_AT);
      repeat ($urandom_range(0, 6)) put_text(tag_char());
      if ($urandom_range(0, 99) < 88) begin
        put_text(CH_AT);
        add_blanks();
      end
    end
    repeat (($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 6))
      put_text(tag_char());
    if ($urandom_range(0, 99) < 75) begin
      k = $urandom_range(0, 99);
      if (k < 80) add_blank();
      else if (k < 87) put_text(CH_VT);
      else if (k < 94) put_text(CH_FF);
      else put_text(CH_CR);
      repeat ($urandom_range(0, 24)) put_text(value_char());
    end
    if ($urandom_range(0, 99) < 35) put_text(CH_CR);
  endtask

  // A line whose first byte is not a digit.
  task automatic add_bad_line();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_LF || (c >= CH_ZERO && c <= CH_NINE));
    put_text(c);
    repeat ($urandom_range(0, 10)) put_text(value_char());
  endtask

  // A note line around the line limit, so offsets and lengths clip.
  task automatic add_long_line();
    int unsigned len;
    int unsigned base;
    len  = $urandom_range(245, 300);
    base = doc_buf.size();
    put_text(8'(CH_ZERO + $urandom_range(0, 9)));
    put_text(CH_SP);
    put_text(8'h4E);
    put_text(8'h4F);
    put_text(8'h54);
    put_text(8'h45);
    put_text(CH_SP);
    while (doc_buf.size() - base < len - 1) put_text(8'($urandom_range(32, 126)));
    put_text(($urandom_range(0, 1) == 0) ? CH_CR : 8'h2E);
  endtask

  // Builds one document in doc_buf: optional leading junk, a level-zero
  // line, then a mix of valid, empty, invalid and long lines. Levels mostly
  // walk the hierarchy legally and sometimes jump.
  task automatic build_document(int unsigned lines, bit want_long);
    int unsigned lvl;
    int unsigned k;
    logic [7:0]  c;
    if ($urandom_range(0, 99) < 30) begin
      repeat ($urandom_range(1, 4)) begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_ZERO);
        put_text(c);
      end
    end
    lvl = 0;
    add_valid_line(0);
    for (int i = 1; i < lines; i++) begin
      put_text(CH_LF);
      k = $urandom_range(0, 99);
      if (want_long && i == 1) add_long_line();
      else if (k < 5) ;
      else if (k < 10) add_bad_line();
      else if (k < 12) add_long_line();
      else begin
        if ($urandom_range(0, 99) < 80) lvl = $urandom_range(0, (lvl < 9) ? lvl + 1 : 9);
        else lvl = $urandom_range(0, 9);
        add_valid_line(lvl);
      end
    end
    // The stream may end on a newline, mid-line, or inside a fresh line.
    k = $urandom_range(0, 99);
    if (k < 50) put_text(CH_LF);
    else if (k < 65) begin
      put_text(CH_LF);
      repeat ($urandom_range(1, 3)) put_text(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_document(bit mark_first, bit mark_end, bit drain);
    for (int i = 0; i < doc_buf.size(); i++)
      add_byte(doc_buf[i], mark_first && i == 0, mark_end && i == doc_buf.size() - 1,
               drain && i == 0);
    doc_buf.delete();
  endtask

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) report_mismatch(what, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Clock.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Byte driver. At each edge an accepted byte is handed to the line scanner
  // and retired from the feed queue; then the next byte is offered once its
  // idle gap has run out. A byte that carries the drain flag waits until no
  // line result is outstanding. Valid stays high across back-to-back bytes.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    bit          offer;
    glt_byte_t   taken;
    glt_result_t res;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      gap_armed = 1'b0;
    end else begin
      offer = in_chan.valid;
      if (in_chan.valid && in_chan.ready) begin
        taken.text_byte  = in_chan.text_byte;
        taken.first_byte = in_chan.first_byte;
        taken.stream_end = in_chan.stream_end;
        if (tokenize_byte(taken, res)) lines_due = {lines_due, res};
        void'(feed_q.pop_front());
        offer     = 1'b0;
        gap_armed = 1'b0;
      end
      if (!offer && feed_q.size() != 0) begin
        if (!gap_armed) begin
          gap_left  = feed_q[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left > 0) gap_left--;
        else if (!feed_q[0].drain || lines_due.size() == 0) offer = 1'b1;
      end
      in_chan.valid <= offer;
      if (offer) begin
        in_chan.text_byte  <= feed_q[0].beat.text_byte;
        in_chan.first_byte <= feed_q[0].beat.first_byte;
        in_chan.stream_end <= feed_q[0].beat.stream_end;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Each accepted line result is compared field by field with
  // the oldest prediction. Ready is stalled at random, with occasional calm
  // stretches in which it stays high.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : line_monitor
    glt_result_t seen;
    glt_result_t want;
    bit          rdy;
    int unsigned r;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left = 0;
      calm_left  = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        seen.line_start     = out_chan.line_start;
        seen.line_ok        = out_chan.line_ok;
        seen.close_before   = out_chan.close_before;
        seen.hierarchy_skip = out_chan.hierarchy_skip;
        seen.tag_level      = out_chan.tag_level;
        seen.xref_offset    = out_chan.xref_offset;
        seen.xref_length    = out_chan.xref_length;
        seen.tag_offset     = out_chan.tag_offset;
        seen.tag_length     = out_chan.tag_length;
        seen.value_offset   = out_chan.value_offset;
        seen.value_length   = out_chan.value_length;
        seen.final_line     = out_chan.final_line;
        if (lines_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("line result with none outstanding, line_start 0x%0h", seen.line_start);
        end else begin
          want = lines_due.pop_front();
          check_field("line_start", want.line_start, seen.line_start);
          check_field("line_ok", want.line_ok, seen.line_ok);
          check_field("close_before", want.close_before, seen.close_before);
          check_field("hierarchy_skip", want.hierarchy_skip, seen.hierarchy_skip);
          check_field("tag_level", want.tag_level, seen.tag_level);
          check_field("xref_offset", want.xref_offset, seen.xref_offset);
          check_field("xref_length", want.xref_length, seen.xref_length);
          check_field("tag_offset", want.tag_offset, seen.tag_offset);
          check_field("tag_length", want.tag_length, seen.tag_length);
          check_field("value_offset", want.value_offset, seen.value_offset);
          check_field("value_length", want.value_length, seen.value_length);
          check_field("final_line", want.final_line, seen.final_line);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        rdy = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          calm_left = $urandom_range(30, 200);
          rdy       = 1'b1;
        end else if (r < 72) begin
          rdy = 1'b1;
        end else begin
          stall_left = idle_span();
          rdy        = 1'b0;
        end
      end
      out_chan.ready <= rdy;
    end
  end

  // A run that never drains ends here.
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned doc_bytes;
    int unsigned docs;
    bit          next_first;
    bit          cut;
    bit          long_doc;

    in_chan.valid      = 1'b0;
    in_chan.text_byte  = 8'h00;
    in_chan.first_byte = 1'b0;
    in_chan.stream_end = 1'b0;
    out_chan.ready     = 1'b0;
    rst_n              = 1'b0;
    cur_level          = 4'd0;
    new_document();

    // Directed document: junk before the first zero, a line with an xref and
    // a bare tag, an empty line, a level jump with a tab-separated value
    // ending in CR, a line that starts with a letter, and a last line whose
    // xref is still open when the stream ends.
    doc_buf = '{8'h5A, 8'hFF, CH_ZERO, CH_SP, CH_AT, 8'h41, CH_AT, CH_SP, 8'h48, CH_LF,
                CH_LF, 8'h33, 8'h54, CH_TAB, 8'h76, CH_CR, CH_LF, 8'h78, CH_LF,
                8'h31, CH_SP, CH_AT, 8'h51};
    send_document(1'b1, 1'b1, 1'b0);
    // A document of a single byte and no zero.
    add_byte(8'h00, 1'b1, 1'b1, 1'b0);

    // Random part: mostly documents, some raw noise with random markers. Some
    // documents are cut short so the next one restarts mid-line, and every
    // twelfth one waits for all outstanding results before it starts.
    doc_bytes  = 0;
    docs       = 0;
    next_first = 1'b1;
    while (doc_bytes < FEED_TARGET) begin
      if ($urandom_range(0, 99) < 8) begin
        in_calm = 1'b0;
        repeat ($urandom_range(1, 8))
          add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
                   $urandom_range(0, 9) == 0, 1'b0);
      end else begin
        in_calm  = ($urandom_range(0, 99) < 20);
        long_doc = (docs == 4 || docs == 9);
        build_document(long_doc ? $urandom_range(2, 6) : $urandom_range(1, 8), long_doc);
        cut       = ($urandom_range(0, 99) < 6);
        doc_bytes += doc_buf.size();
        send_document(next_first || $urandom_range(0, 99) < 90, !cut, docs % 12 == 0);
        next_first = cut;
        docs++;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (feed_q.size() != 0 || in_chan.valid) @(posedge clk);
    while (lines_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- gedcom_line_tokenizer_core.f -----
+incdir+design
design/glt_pkg.sv
design/glt_channels.sv
design/glt_scan.sv
design/gedcom_line_tokenizer_core.sv
tb/tb_gedcom_line_tokenizer_core.sv
